// ===== rtl/core/hough_line_point_distance_assert.svh =====
// assertion macros shared by the checker of the point-to-line distance block
// depends on: a clock named clock and a reset named reset in the using scope
`ifndef HOUGH_LINE_POINT_DISTANCE_ASSERT_SVH
`define HOUGH_LINE_POINT_DISTANCE_ASSERT_SVH

// same-cycle implication, off during reset
`define HLPD_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, off during reset
`define HLPD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/hlpd_pkg.sv =====
// package for the point-to-line distance block: widths, stage map, cordic table
// and the pipeline payload type; depends on nothing
`default_nettype none

package hlpd_pkg;

   // segment half length in pixels and its scaled form (16 * half length)
   localparam int SEG_HALF_LEN = 1000;
   localparam logic signed [18:0] HS_VAL = 19'(16 * SEG_HALF_LEN);

   // port widths
   localparam int REQ_W = 72;
   localparam int RSP_W = 24;
   localparam logic [16:0] DIST_MAX = 17'h1FFFF;

   // arithmetic widths
   localparam int DEN_W  = 28;
   localparam int QUO_W  = 36;
   localparam int ROOT_W = 22;
   localparam int RAD_W  = 2 * ROOT_W;

   // cordic start value, K * 2^30
   localparam logic signed [32:0] CORDIC_X0 = 33'sd652032874;
   localparam int CORDIC_N = 16;

   // stage map
   localparam int DIV_STAGES  = QUO_W / 2;
   localparam int SQRT_STAGES = ROOT_W / 2;
   localparam int ST_LOAD    = 0;
   localparam int ST_CORDIC  = 1;
   localparam int ST_FOLD    = ST_CORDIC + CORDIC_N;
   localparam int ST_PROD    = ST_FOLD + 1;
   localparam int ST_END     = ST_PROD + 1;
   localparam int ST_DIFF    = ST_END + 1;
   localparam int ST_MUL     = ST_DIFF + 1;
   localparam int ST_NUMDEN  = ST_MUL + 1;
   localparam int ST_DIVSET  = ST_NUMDEN + 1;
   localparam int ST_DIV     = ST_DIVSET + 1;
   localparam int ST_SIGN    = ST_DIV + DIV_STAGES;
   localparam int ST_RMUL    = ST_SIGN + 1;
   localparam int ST_FOOT    = ST_RMUL + 1;
   localparam int ST_SQ      = ST_FOOT + 1;
   localparam int ST_RAD     = ST_SQ + 1;
   localparam int ST_SQRT    = ST_RAD + 1;
   localparam int ST_SAT     = ST_SQRT + SQRT_STAGES;
   localparam int NUM_STAGES = ST_SAT + 1;

   // payload carried down the pipeline; unused fields are trimmed by synthesis
   typedef struct packed {
      logic signed [16:0]   rho;
      logic [15:0]          theta;
      logic signed [15:0]   px;
      logic signed [15:0]   py;
      logic signed [32:0]   cx;
      logic signed [32:0]   cy;
      logic signed [32:0]   cz;
      logic signed [17:0]   c;
      logic signed [17:0]   s;
      logic signed [35:0]   pcr;
      logic signed [35:0]   psr;
      logic signed [35:0]   phs;
      logic signed [35:0]   phc;
      logic signed [15:0]   x1;
      logic signed [15:0]   y1;
      logic signed [15:0]   x2;
      logic signed [15:0]   y2;
      logic signed [15:0]   dx;
      logic signed [15:0]   dy;
      logic signed [17:0]   qx;
      logic signed [17:0]   qy;
      logic signed [33:0]   mx;
      logic signed [33:0]   my;
      logic signed [31:0]   dxx;
      logic signed [31:0]   dyy;
      logic signed [33:0]   num;
      logic [DEN_W-1:0]     den;
      logic                 neg;
      logic [DEN_W:0]       drem;
      logic [QUO_W-1:0]     dlo;
      logic [QUO_W-1:0]     quo;
      logic signed [QUO_W:0] ratio;
      logic signed [52:0]   rx;
      logic signed [52:0]   ry;
      logic signed [20:0]   ex;
      logic signed [20:0]   ey;
      logic [41:0]          ex2;
      logic [41:0]          ey2;
      logic [RAD_W-1:0]     rad;
      logic [ROOT_W+1:0]    srem;
      logic [ROOT_W-1:0]    root;
      logic [16:0]          distance;
   } pipe_type;

   // arctangent table, angle in units of 2^-32 turn
   function automatic logic signed [32:0] atan_val(input int i);
      logic signed [32:0] v;
      case (i)
         0:  v = 33'sd536870912;
         1:  v = 33'sd316933406;
         2:  v = 33'sd167458907;
         3:  v = 33'sd85004756;
         4:  v = 33'sd42667331;
         5:  v = 33'sd21354465;
         6:  v = 33'sd10679838;
         7:  v = 33'sd5340245;
         8:  v = 33'sd2670163;
         9:  v = 33'sd1335087;
         10: v = 33'sd667544;
         11: v = 33'sd333772;
         12: v = 33'sd166886;
         13: v = 33'sd83443;
         14: v = 33'sd41722;
         15: v = 33'sd20861;
         default: v = 33'sd0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/hough_line_point_distance.sv =====
// Usage:
//   Computes the truncated distance from a pixel point to a line given in
//   Hough normal form (rho, theta).
//   Request channel req_*: one request per accepted beat (tvalid and tready
//   high at a rising edge) carrying rho, theta, px and py.
//   Response channel rsp_*: one distance per request, in request order.
//   Depth: 59 register stages, from the load stage to the saturation stage.
//   Throughput: one request per cycle while the pipeline is not stalled; the depth
//   comes from the 16-step cordic, the 2-bit-per-stage divider (18 stages) and
//   the 2-bit-per-stage square root (11 stages).
//   Stall: when a response waits and rsp_tready is low, the whole pipeline
//   holds and req_tready drops; nothing is lost or repeated.
//   Reset: synchronous, active high; clears all stage valid bits, so no
//   response is shown after reset.
// depends on: hlpd_pkg
`default_nettype none

module hough_line_point_distance (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        req_tvalid,
   output logic                             req_tready,
   // rho[16:0], theta[32:17], px[48:33], py[64:49], zero fill above
   input  wire logic [hlpd_pkg::REQ_W-1:0]  req_tdata,
   output logic                             rsp_tvalid,
   input  wire logic                        rsp_tready,
   // distance[16:0], zero fill above
   output logic [hlpd_pkg::RSP_W-1:0]       rsp_tdata
);
   import hlpd_pkg::*;

   pipe_type              stage_ff [NUM_STAGES];
   pipe_type              stage_in [NUM_STAGES];
   logic [NUM_STAGES-1:0] valid_ff;
   logic [NUM_STAGES-1:0] valid_in;
   logic                  adv;

   // unpack a request and seed the cordic
   function automatic pipe_type f_load(input logic [REQ_W-1:0] d);
      pipe_type p;
      p       = '0;
      p.rho   = signed'(d[16:0]);
      p.theta = d[32:17];
      p.px    = signed'(d[48:33]);
      p.py    = signed'(d[64:49]);
      p.cx    = CORDIC_X0;
      p.cy    = '0;
      p.cz    = signed'({3'b000, d[31:17], 15'b0});
      return p;
   endfunction

   // one cordic rotation step
   function automatic pipe_type f_cordic(input pipe_type pi, input int i);
      pipe_type p;
      logic signed [32:0] xs;
      logic signed [32:0] ys;
      p  = pi;
      xs = pi.cx >>> i;
      ys = pi.cy >>> i;
      if (pi.cz >= 0) begin
         p.cx = pi.cx - ys;
         p.cy = pi.cy + xs;
         p.cz = pi.cz - atan_val(i);
      end else begin
         p.cx = pi.cx + ys;
         p.cy = pi.cy - xs;
         p.cz = pi.cz + atan_val(i);
      end
      return p;
   endfunction

   // round half away from zero by 14, clamp to one
   function automatic logic signed [17:0] f_unit(input logic signed [32:0] v);
      logic signed [32:0] r;
      logic [32:0]        m;
      if (v >= 0) begin
         r = (v + 33'sd8192) >>> 14;
      end else begin
         m = unsigned'(-v) + 33'd8192;
         r = -signed'(m >> 14);
      end
      if (r > 33'sd65536) begin
         r = 33'sd65536;
      end else if (r < -33'sd65536) begin
         r = -33'sd65536;
      end
      return 18'(r);
   endfunction

   // cos and sin with the quadrant folded back
   function automatic pipe_type f_fold(input pipe_type pi);
      pipe_type p;
      logic signed [17:0] cq;
      logic signed [17:0] sq;
      p  = pi;
      cq = f_unit(pi.cx);
      sq = f_unit(pi.cy);
      if (pi.theta[15]) begin
         p.c = -sq;
         p.s = cq;
      end else begin
         p.c = cq;
         p.s = sq;
      end
      return p;
   endfunction

   // products for the endpoints
   function automatic pipe_type f_prod(input pipe_type pi);
      pipe_type p;
      p     = pi;
      p.pcr = 36'(pi.c * pi.rho);
      p.psr = 36'(pi.s * pi.rho);
      p.phs = 36'(pi.s * HS_VAL);
      p.phc = 36'(pi.c * HS_VAL);
      return p;
   endfunction

   // round half away from zero by 20
   function automatic logic signed [15:0] f_rnd20(input logic signed [35:0] v);
      logic [35:0] m;
      logic signed [35:0] r;
      if (v >= 0) begin
         r = (v + 36'sd524288) >>> 20;
      end else begin
         m = unsigned'(-v) + 36'd524288;
         r = -signed'(m >> 20);
      end
      return 16'(r);
   endfunction

   // endpoints
   function automatic pipe_type f_end(input pipe_type pi);
      pipe_type p;
      p    = pi;
      p.x1 = f_rnd20(pi.pcr - pi.phs);
      p.y1 = f_rnd20(pi.psr + pi.phc);
      p.x2 = f_rnd20(pi.pcr + pi.phs);
      p.y2 = f_rnd20(pi.psr - pi.phc);
      return p;
   endfunction

   // direction and point offset
   function automatic pipe_type f_diff(input pipe_type pi);
      pipe_type p;
      p    = pi;
      p.dx = pi.x2 - pi.x1;
      p.dy = pi.y2 - pi.y1;
      p.qx = 18'(pi.px) - 18'(pi.x1);
      p.qy = 18'(pi.py) - 18'(pi.y1);
      return p;
   endfunction

   // dot and length products
   function automatic pipe_type f_mul(input pipe_type pi);
      pipe_type p;
      p     = pi;
      p.mx  = 34'(pi.qx * pi.dx);
      p.my  = 34'(pi.qy * pi.dy);
      p.dxx = 32'(pi.dx * pi.dx);
      p.dyy = 32'(pi.dy * pi.dy);
      return p;
   endfunction

   // numerator and denominator
   function automatic pipe_type f_numden(input pipe_type pi);
      pipe_type p;
      p     = pi;
      p.num = pi.mx + pi.my;
      p.den = DEN_W'(unsigned'(pi.dxx + pi.dyy));
      return p;
   endfunction

   // divider setup: magnitude of num shifted by 24
   function automatic pipe_type f_divset(input pipe_type pi);
      pipe_type p;
      logic [33:0] mag;
      logic [57:0] full;
      p      = pi;
      p.neg  = pi.num < 0;
      mag    = p.neg ? unsigned'(-pi.num) : unsigned'(pi.num);
      full   = {mag, 24'b0};
      p.drem = (DEN_W + 1)'(full[57:QUO_W]);
      p.dlo  = full[QUO_W-1:0];
      p.quo  = '0;
      return p;
   endfunction

   // two restoring division steps
   function automatic pipe_type f_div(input pipe_type pi);
      pipe_type p;
      logic [DEN_W+1:0] r2;
      p = pi;
      for (int k = 0; k < 2; k++) begin
         r2    = {p.drem, p.dlo[QUO_W-1]};
         p.dlo = {p.dlo[QUO_W-2:0], 1'b0};
         if (r2 >= (DEN_W + 2)'(p.den)) begin
            p.drem = (DEN_W + 1)'(r2 - (DEN_W + 2)'(p.den));
            p.quo  = {p.quo[QUO_W-2:0], 1'b1};
         end else begin
            p.drem = (DEN_W + 1)'(r2);
            p.quo  = {p.quo[QUO_W-2:0], 1'b0};
         end
      end
      return p;
   endfunction

   // signed ratio, zero for a zero-length segment
   function automatic pipe_type f_sign(input pipe_type pi);
      pipe_type p;
      logic signed [QUO_W:0] q;
      p = pi;
      q = signed'({1'b0, pi.quo});
      if (pi.den == '0) begin
         p.ratio = '0;
      end else begin
         p.ratio = pi.neg ? -q : q;
      end
      return p;
   endfunction

   // ratio times direction
   function automatic pipe_type f_rmul(input pipe_type pi);
      pipe_type p;
      p    = pi;
      p.rx = 53'(pi.ratio * pi.dx);
      p.ry = 53'(pi.ratio * pi.dy);
      return p;
   endfunction

   // foot coordinate truncated toward zero
   function automatic logic signed [19:0] f_foot1(input logic signed [15:0] e,
                                                 input logic signed [52:0] r);
      logic signed [53:0] sx;
      sx = (54'(e) <<< 24) + 54'(r);
      if (sx < 0) begin
         sx = sx + 54'sd16777215;
      end
      return 20'(sx >>> 24);
   endfunction

   // offset from point to foot
   function automatic pipe_type f_foot(input pipe_type pi);
      pipe_type p;
      p    = pi;
      p.ex = 21'(f_foot1(pi.x1, pi.rx)) - 21'(pi.px);
      p.ey = 21'(f_foot1(pi.y1, pi.ry)) - 21'(pi.py);
      return p;
   endfunction

   // squares
   function automatic pipe_type f_sq(input pipe_type pi);
      pipe_type p;
      p     = pi;
      p.ex2 = unsigned'(42'(pi.ex * pi.ex));
      p.ey2 = unsigned'(42'(pi.ey * pi.ey));
      return p;
   endfunction

   // radicand and square root seed
   function automatic pipe_type f_rad(input pipe_type pi);
      pipe_type p;
      p      = pi;
      p.rad  = RAD_W'(pi.ex2) + RAD_W'(pi.ey2);
      p.srem = '0;
      p.root = '0;
      return p;
   endfunction

   // two digit-by-digit square root steps
   function automatic pipe_type f_sqrt(input pipe_type pi);
      pipe_type p;
      logic [ROOT_W+3:0] r2;
      logic [ROOT_W+3:0] trial;
      p = pi;
      for (int k = 0; k < 2; k++) begin
         r2    = {p.srem, p.rad[RAD_W-1:RAD_W-2]};
         p.rad = {p.rad[RAD_W-3:0], 2'b00};
         trial = {2'b00, p.root, 2'b01};
         if (r2 >= trial) begin
            p.srem = (ROOT_W + 2)'(r2 - trial);
            p.root = {p.root[ROOT_W-2:0], 1'b1};
         end else begin
            p.srem = (ROOT_W + 2)'(r2);
            p.root = {p.root[ROOT_W-2:0], 1'b0};
         end
      end
      return p;
   endfunction

   // saturation
   function automatic pipe_type f_sat(input pipe_type pi);
      pipe_type p;
      p = pi;
      if (pi.root > ROOT_W'(DIST_MAX)) begin
         p.distance = DIST_MAX;
      end else begin
         p.distance = pi.root[16:0];
      end
      return p;
   endfunction

   // global advance: move when the last stage is empty or being taken
   assign adv        = !valid_ff[NUM_STAGES-1] || rsp_tready;
   assign req_tready = adv;
   assign valid_in   = {valid_ff[NUM_STAGES-2:0], req_tvalid};

   // stage next values
   assign stage_in[ST_LOAD] = f_load(req_tdata);
   for (genvar g = 0; g < CORDIC_N; g++) begin : g_cordic
      assign stage_in[ST_CORDIC+g] = f_cordic(stage_ff[ST_CORDIC+g-1], g);
   end
   assign stage_in[ST_FOLD]   = f_fold(stage_ff[ST_FOLD-1]);
   assign stage_in[ST_PROD]   = f_prod(stage_ff[ST_PROD-1]);
   assign stage_in[ST_END]    = f_end(stage_ff[ST_END-1]);
   assign stage_in[ST_DIFF]   = f_diff(stage_ff[ST_DIFF-1]);
   assign stage_in[ST_MUL]    = f_mul(stage_ff[ST_MUL-1]);
   assign stage_in[ST_NUMDEN] = f_numden(stage_ff[ST_NUMDEN-1]);
   assign stage_in[ST_DIVSET] = f_divset(stage_ff[ST_DIVSET-1]);
   for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
      assign stage_in[ST_DIV+g] = f_div(stage_ff[ST_DIV+g-1]);
   end
   assign stage_in[ST_SIGN]   = f_sign(stage_ff[ST_SIGN-1]);
   assign stage_in[ST_RMUL]   = f_rmul(stage_ff[ST_RMUL-1]);
   assign stage_in[ST_FOOT]   = f_foot(stage_ff[ST_FOOT-1]);
   assign stage_in[ST_SQ]     = f_sq(stage_ff[ST_SQ-1]);
   assign stage_in[ST_RAD]    = f_rad(stage_ff[ST_RAD-1]);
   for (genvar g = 0; g < SQRT_STAGES; g++) begin : g_sqrt
      assign stage_in[ST_SQRT+g] = f_sqrt(stage_ff[ST_SQRT+g-1]);
   end
   assign stage_in[ST_SAT]    = f_sat(stage_ff[ST_SAT-1]);

   // stage valid bits
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (adv) begin
         valid_ff <= valid_in;
      end
   end

   // stage payload
   always_ff @(posedge clock) begin
      if (adv) begin
         stage_ff <= stage_in;
      end
   end

   // response
   assign rsp_tvalid = valid_ff[NUM_STAGES-1];
   assign rsp_tdata  = {(RSP_W - 17)'(0), stage_ff[NUM_STAGES-1].distance};

endmodule

`default_nettype wire

// ===== rtl/core/hlpd_checker.sv =====
// port-level checks for the point-to-line distance block, bound to its top
// depends on: hough_line_point_distance_assert.svh
`default_nettype none

module hlpd_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [23:0] rsp_tdata
);
`include "hough_line_point_distance_assert.svh"

   // a stalled response freezes the whole pipeline
   `HLPD_ASSERT_SAME(a_stall_blocks_req, rsp_tvalid && !rsp_tready, !req_tready, "request taken during stall")
   // an empty output stage never blocks requests
   `HLPD_ASSERT_SAME(a_empty_takes_req, !rsp_tvalid, req_tready, "request refused with empty output")
   // a stalled response holds
   `HLPD_ASSERT_NEXT(a_rsp_hold, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata), "stalled response changed")
   // distance fill bits stay zero
   `HLPD_ASSERT_SAME(a_rsp_fill, rsp_tvalid, rsp_tdata[23:17] == 7'd0, "response fill bits set")

endmodule

bind hough_line_point_distance hlpd_checker u_hlpd_checker (.*);

`default_nettype wire
